// ===== src/esid_pkg.sv =====
// ----------------------------------------------------------------------------
// esid_pkg
// Shared types and constants of the edge set insert unit: request and result
// layouts, status codes, register indexes and the control interface between
// the controller and the datapath.
// ----------------------------------------------------------------------------
package esid_pkg;

  // Width of a node index in a request.
  localparam int NODE_W = 8;
  // Number of node indexes a request can name.
  localparam int NODE_SPAN = 1 << NODE_W;

  localparam int STATUS_W = 2;
  localparam int COUNT_W = 11;
  localparam int DEGREE_W = 12;
  localparam int LIMIT_W = 9;
  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W = 9;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_ADDED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DUPLICATE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_DIRECTED = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_NODE_LIMIT = 4'd1;

  // Register reset values.
  localparam logic LIMIT_RESET_DIRECTED = 1'b0;
  localparam logic [LIMIT_W-1:0] NODE_LIMIT_RESET = 9'd256;

  // Degree arithmetic.
  localparam logic [DEGREE_W-1:0] DEGREE_MAX = 12'd4095;
  localparam logic [1:0] SELF_LOOP_WEIGHT = 2'd2;

  typedef struct packed {
    logic [NODE_W-1:0] src_node;
    logic [NODE_W-1:0] dst_node;
  } item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0] stored_edges;
    logic [DEGREE_W-1:0] src_degree;
    logic [DEGREE_W-1:0] dst_degree;
  } result_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic deg_read;
    logic scan_clear;
    logic scan_issue;
    logic edge_write;
    logic deg_write_src;
    logic deg_write_dst;
    logic res_load;
    logic [STATUS_W-1:0] res_status;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic range_bad;
    logic table_full;
    logic table_empty;
    logic scan_last;
    logic hit;
    logic self_loop;
  } dp_stat_t;

endpackage

// ===== src/esid_ctrl.sv =====
// ----------------------------------------------------------------------------
// esid_ctrl
// Controller of the edge set insert unit. Sequences the checks, the scan of
// the edge table, the table and degree updates and the result strobe.
// ----------------------------------------------------------------------------
module esid_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  output logic              done,
  output esid_pkg::dp_cmd_t cmd,
  input  esid_pkg::dp_stat_t stat
);
  import esid_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CHECK  = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_DRAIN  = 3'd3;
  localparam logic [2:0] S_ADD    = 3'd4;
  localparam logic [2:0] S_ADD2   = 3'd5;
  localparam logic [2:0] S_REPORT = 3'd6;
  localparam logic [2:0] S_REFUSE = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_next = state;
    cmd = '0;
    cmd.res_status = ST_ADDED;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.deg_read = 1'b1;
        cmd.scan_clear = 1'b1;
        if (stat.range_bad || stat.table_full) begin
          state_next = S_REFUSE;
        end else if (stat.table_empty) begin
          state_next = S_ADD;
        end else begin
          state_next = S_SCAN;
        end
      end
      S_REFUSE: begin
        // The degrees read in the check cycle are available now.
        cmd.res_load = 1'b1;
        cmd.res_status = stat.range_bad ? ST_RANGE : ST_FULL;
        state_next = S_REPORT;
      end
      S_SCAN: begin
        cmd.scan_issue = 1'b1;
        if (stat.scan_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // The last table read is compared in this cycle.
        if (stat.hit) begin
          cmd.res_load = 1'b1;
          cmd.res_status = ST_DUPLICATE;
          state_next = S_REPORT;
        end else begin
          state_next = S_ADD;
        end
      end
      S_ADD: begin
        cmd.edge_write = 1'b1;
        cmd.deg_write_src = 1'b1;
        cmd.res_load = 1'b1;
        cmd.res_status = ST_ADDED;
        state_next = stat.self_loop ? S_REPORT : S_ADD2;
      end
      S_ADD2: begin
        cmd.deg_write_dst = 1'b1;
        state_next = S_REPORT;
      end
      S_REPORT: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_REPORT);

endmodule

// ===== src/esid_dp.sv =====
// ----------------------------------------------------------------------------
// esid_dp
// Datapath of the edge set insert unit: configuration registers, the edge
// table memory with its fill count and scan pointer, the per-node degree
// memory with valid bits, and the result register.
// ----------------------------------------------------------------------------
module esid_dp #(
  parameter int EDGE_CAPACITY = 1024,
  parameter int NODE_CAPACITY = 256
) (
  input  logic                               clk,
  input  logic                               rst,
  input  esid_pkg::item_t                    item,
  input  esid_pkg::dp_cmd_t                  cmd,
  output esid_pkg::dp_stat_t                 stat,
  output esid_pkg::result_t                  result,
  input  logic                               cfg_valid,
  input  logic [esid_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [esid_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import esid_pkg::*;

  localparam int EDGE_AW = (EDGE_CAPACITY > 1) ? $clog2(EDGE_CAPACITY) : 1;
  localparam int EDGE_CW = $clog2(EDGE_CAPACITY + 1);
  localparam int DEG_DEPTH = (NODE_CAPACITY < NODE_SPAN) ? NODE_CAPACITY : NODE_SPAN;
  localparam int DEG_AW = $clog2(DEG_DEPTH);

  // Configuration registers.
  logic               directed_mode;
  logic [LIMIT_W-1:0] node_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      directed_mode <= LIMIT_RESET_DIRECTED;
      node_limit <= NODE_LIMIT_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == REG_DIRECTED) begin
        directed_mode <= cfg_data[0];
      end else if (cfg_index == REG_NODE_LIMIT) begin
        node_limit <= cfg_data[LIMIT_W-1:0];
      end
    end
  end

  // Request capture.
  logic [NODE_W-1:0] src_q;
  logic [NODE_W-1:0] dst_q;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      src_q <= item.src_node;
      dst_q <= item.dst_node;
    end
  end

  // Range and capacity checks.
  logic src_in_cap;
  logic dst_in_cap;
  logic src_ok;
  logic dst_ok;

  assign src_in_cap = (32'(src_q) < NODE_CAPACITY);
  assign dst_in_cap = (32'(dst_q) < NODE_CAPACITY);
  assign src_ok = ({1'b0, src_q} < node_limit) && src_in_cap;
  assign dst_ok = ({1'b0, dst_q} < node_limit) && dst_in_cap;

  // Edge count.
  logic [EDGE_CW-1:0] edge_total;

  always_ff @(posedge clk) begin
    if (rst) begin
      edge_total <= '0;
    end else if (cmd.edge_write) begin
      edge_total <= edge_total + 1'b1;
    end
  end

  // Edge table memory, source in the high byte.
  logic [2*NODE_W-1:0] edge_mem [EDGE_CAPACITY];
  logic [2*NODE_W-1:0] edge_rd;
  logic [EDGE_CW-1:0]  scan_idx;

  always_ff @(posedge clk) begin
    if (cmd.edge_write) begin
      edge_mem[edge_total[EDGE_AW-1:0]] <= {src_q, dst_q};
    end
    if (cmd.scan_issue) begin
      edge_rd <= edge_mem[scan_idx[EDGE_AW-1:0]];
    end
  end

  // Scan pointer, read-valid flag and the sticky match flag.
  logic               rd_vld;
  logic               hit_q;
  logic               match;

  assign match = rd_vld &&
                 ((edge_rd == {src_q, dst_q}) ||
                  (!directed_mode && (edge_rd == {dst_q, src_q})));

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx <= '0;
      rd_vld <= 1'b0;
      hit_q <= 1'b0;
    end else begin
      rd_vld <= cmd.scan_issue;
      if (cmd.scan_clear) begin
        scan_idx <= '0;
        hit_q <= 1'b0;
      end else begin
        if (cmd.scan_issue) begin
          scan_idx <= scan_idx + 1'b1;
        end
        if (match) begin
          hit_q <= 1'b1;
        end
      end
    end
  end

  // Degree memory with one valid bit per node; a node never written reads 0.
  logic [DEGREE_W-1:0] deg_mem [DEG_DEPTH];
  logic [DEG_DEPTH-1:0] deg_vld;
  logic [DEG_AW-1:0]   src_idx;
  logic [DEG_AW-1:0]   dst_idx;
  logic [DEGREE_W-1:0] src_rd_raw;
  logic [DEGREE_W-1:0] dst_rd_raw;
  logic                src_rd_vld;
  logic                dst_rd_vld;
  logic [DEGREE_W-1:0] src_deg;
  logic [DEGREE_W-1:0] dst_deg;
  logic [DEG_AW-1:0]   wr_idx;
  logic [DEGREE_W-1:0] wr_deg;

  assign src_idx = src_q[DEG_AW-1:0];
  assign dst_idx = dst_q[DEG_AW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.deg_read) begin
      src_rd_raw <= deg_mem[src_idx];
      dst_rd_raw <= deg_mem[dst_idx];
    end
    if (cmd.deg_write_src || cmd.deg_write_dst) begin
      deg_mem[wr_idx] <= wr_deg;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      deg_vld <= '0;
      src_rd_vld <= 1'b0;
      dst_rd_vld <= 1'b0;
    end else begin
      if (cmd.deg_read) begin
        src_rd_vld <= deg_vld[src_idx] && src_in_cap;
        dst_rd_vld <= deg_vld[dst_idx] && dst_in_cap;
      end
      if (cmd.deg_write_src || cmd.deg_write_dst) begin
        deg_vld[wr_idx] <= 1'b1;
      end
    end
  end

  assign src_deg = src_rd_vld ? src_rd_raw : '0;
  assign dst_deg = dst_rd_vld ? dst_rd_raw : '0;

  // Saturating degree updates; a self-loop adds two to one node.
  logic                self_loop;
  logic [DEGREE_W:0]   src_sum;
  logic [DEGREE_W:0]   dst_sum;
  logic [DEGREE_W-1:0] src_new;
  logic [DEGREE_W-1:0] dst_new;

  assign self_loop = (src_q == dst_q);
  assign src_sum = {1'b0, src_deg} +
                   (self_loop ? (DEGREE_W + 1)'(SELF_LOOP_WEIGHT) : (DEGREE_W + 1)'(1));
  assign dst_sum = {1'b0, dst_deg} + (DEGREE_W + 1)'(1);
  assign src_new = (src_sum > {1'b0, DEGREE_MAX}) ? DEGREE_MAX : src_sum[DEGREE_W-1:0];
  assign dst_new = self_loop ? src_new :
                   ((dst_sum > {1'b0, DEGREE_MAX}) ? DEGREE_MAX : dst_sum[DEGREE_W-1:0]);

  assign wr_idx = cmd.deg_write_dst ? dst_idx : src_idx;
  assign wr_deg = cmd.deg_write_dst ? dst_new : src_new;

  // Result register; the edge count is taken live since it settles first.
  logic [STATUS_W-1:0] res_status;
  logic [DEGREE_W-1:0] res_src_deg;
  logic [DEGREE_W-1:0] res_dst_deg;

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      res_status <= cmd.res_status;
      if (cmd.res_status == ST_ADDED) begin
        res_src_deg <= src_new;
        res_dst_deg <= dst_new;
      end else begin
        res_src_deg <= src_deg;
        res_dst_deg <= dst_deg;
      end
    end
  end

  assign result.status = res_status;
  assign result.stored_edges = COUNT_W'(edge_total);
  assign result.src_degree = res_src_deg;
  assign result.dst_degree = res_dst_deg;

  // Status toward the controller.
  assign stat.range_bad = !(src_ok && dst_ok);
  assign stat.table_full = (32'(edge_total) >= EDGE_CAPACITY);
  assign stat.table_empty = (edge_total == '0);
  assign stat.scan_last = ({1'b0, scan_idx} + (EDGE_CW + 1)'(1) == {1'b0, edge_total});
  assign stat.hit = hit_q || match;
  assign stat.self_loop = self_loop;

endmodule

// ===== src/edge_set_insert_with_degree_unit.sv =====
// ----------------------------------------------------------------------------
// edge_set_insert_with_degree_unit
// Keeps a table of distinct edges and a degree count per node. Each request
// offers one edge; the unit reports whether it was added or why it was
// refused, the number of edges held and both endpoint degrees.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake                 Payload
//   --------  ------------------------  -----------------------------------
//   request   start, busy               item (src_node, dst_node)
//   result    done (one-cycle strobe)   result (status, stored_edges,
//                                       src_degree, dst_degree)
//   config    cfg_valid, cfg_ready      cfg_index, cfg_data
//
// A request that is out of range or meets a full table passes through the
// check, refuse and report states. Otherwise the edge table is scanned one
// entry per cycle through its single read port; then a duplicate is reported,
// or the edge is added and the source and destination degrees are written
// (one degree write for a self-loop); into an empty table the scan is skipped.
// Reset does not walk the memories: the degree store is cleared by per-node
// valid bits, and the edge table is bounded by its count.
// The result strobe cannot be stalled; busy stays high through the strobe.
//
module edge_set_insert_with_degree_unit #(
  parameter int EDGE_CAPACITY = 1024,
  parameter int NODE_CAPACITY = 256
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  esid_pkg::item_t                  item,
  output logic                             done,
  output esid_pkg::result_t                result,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [esid_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [esid_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import esid_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Configuration writes are always taken.
  assign cfg_ready = 1'b1;

  esid_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd),
    .stat  (stat)
  );

  esid_dp #(
    .EDGE_CAPACITY (EDGE_CAPACITY),
    .NODE_CAPACITY (NODE_CAPACITY)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .cmd       (cmd),
    .stat      (stat),
    .result    (result),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule

// ===== src/esid_checker.sv =====
// ----------------------------------------------------------------------------
// esid_checker
// Port-level checks of the edge set insert unit: request acceptance, the
// single result strobe per request, the return to idle and a nonzero source degree on an added edge.
// ----------------------------------------------------------------------------
module esid_checker (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              done,
  input esid_pkg::result_t result
);
  import esid_pkg::*;

  // An accepted request makes the unit busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

  // A result is only shown while a request is in flight.
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy)
    else $error("result strobe while idle");

  // Exactly one result per request: the strobe is followed by idle.
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> (!done && !busy))
    else $error("result strobe not followed by idle");

  // An added edge always leaves its source with a nonzero degree.
  a_added_nonzero: assert property (@(posedge clk) disable iff (rst)
    (done && (result.status == ST_ADDED)) |-> (result.src_degree != '0))
    else $error("added edge reports zero source degree");

endmodule

bind edge_set_insert_with_degree_unit esid_checker u_esid_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the edge set insert unit. Edge requests are driven
// with random gaps and compared against a cycle-free prediction of the edge
// table, the node degrees and the status code. The run covers both modes,
// node limits from zero to above capacity, self-loops and duplicates in
// either order.
// ----------------------------------------------------------------------------
module tb_top;
  import esid_pkg::*;

  localparam int TABLE_DEPTH = 1024;
  localparam int NODE_DEPTH = 256;
  localparam int MAX_SHOWN = 10;
  // The longest correct pause is a full table scan plus the longest request
  // gap; allow several times that.
  localparam int QUIET_LIMIT = 8000;

  // Predicts each insert and checks the results in order.
  class edge_set_scoreboard;
    bit [15:0] edge_keys[$];
    bit [DEGREE_W-1:0] degree[NODE_DEPTH];
    bit directed;
    bit [LIMIT_W-1:0] node_limit;
    result_t pending_results[$];
    int status_seen[4];
    int request_count;
    int result_count;
    int fault_count;

    function new();
      directed = LIMIT_RESET_DIRECTED;
      node_limit = NODE_LIMIT_RESET;
    endfunction

    function void set_register(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
      case (index)
        REG_DIRECTED: directed = data[0];
        REG_NODE_LIMIT: node_limit = data;
        default: ;
      endcase
    endfunction

    // Limits above the node capacity behave as the capacity.
    function int active_limit();
      return (node_limit > NODE_DEPTH) ? NODE_DEPTH : int'(node_limit);
    endfunction

    function bit holds(bit [7:0] a, bit [7:0] b);
      foreach (edge_keys[i]) begin
        if (edge_keys[i] == {a, b}) return 1'b1;
      end
      return 1'b0;
    endfunction

    function void bump_degree(bit [7:0] node, int amount);
      int sum;
      sum = int'(degree[node]) + amount;
      if (sum > int'(DEGREE_MAX)) sum = int'(DEGREE_MAX);
      degree[node] = DEGREE_W'(sum);
    endfunction

    // Range is checked first, then a full table, then a duplicate.
    function result_t predict_insert(item_t it);
      result_t r;
      bit [7:0] s;
      bit [7:0] d;
      int lim;
      s = it.src_node;
      d = it.dst_node;
      lim = active_limit();
      if (s >= lim || d >= lim) begin
        r.status = ST_RANGE;
      end else if (edge_keys.size() >= TABLE_DEPTH) begin
        r.status = ST_FULL;
      end else if (holds(s, d) || (!directed && holds(d, s))) begin
        r.status = ST_DUPLICATE;
      end else begin
        edge_keys.push_back({s, d});
        if (s == d) begin
          bump_degree(s, int'(SELF_LOOP_WEIGHT));
        end else begin
          bump_degree(s, 1);
          bump_degree(d, 1);
        end
        r.status = ST_ADDED;
      end
      r.stored_edges = COUNT_W'(edge_keys.size());
      r.src_degree = degree[s];
      r.dst_degree = degree[d];
      return r;
    endfunction

    function void note_request(item_t it);
      result_t r;
      r = predict_insert(it);
      pending_results.push_back(r);
      status_seen[r.status]++;
      request_count++;
    endfunction

    function void check_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
        fault_count++;
        if (fault_count <= MAX_SHOWN)
          $display("Mismatch in %s of result %0d: expected %0d, got %0d",
                   name, result_count, want, got);
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending_results.size() == 0) begin
        fault_count++;
        if (fault_count <= MAX_SHOWN)
          $display("Result with no request outstanding: status %0d edges %0d",
                   got.status, got.stored_edges);
      end else begin
        want = pending_results.pop_front();
        check_field("status", 16'(want.status), 16'(got.status));
        check_field("stored_edges", 16'(want.stored_edges), 16'(got.stored_edges));
        check_field("src_degree", 16'(want.src_degree), 16'(got.src_degree));
        check_field("dst_degree", 16'(want.dst_degree), 16'(got.dst_degree));
      end
      result_count++;
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  item_t item = '0;
  logic done;
  result_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  edge_set_scoreboard sb;
  bit steady_flow;
  int write_count;
  int quiet_cycles;

  edge_set_insert_with_degree_unit #(
    .EDGE_CAPACITY(TABLE_DEPTH),
    .NODE_CAPACITY(NODE_DEPTH)
  ) uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .item(item),
    .done(done),
    .result(result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Results are strobed for one cycle and checked as they appear.
  always @(posedge clk) begin
    if (!rst && done) sb.check_result(result);
  end

  // Ends the run if nothing moves for too long.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Timeout: no activity for %0d cycles", QUIET_LIMIT);
      $display("FAIL edge_set_insert_with_degree_unit");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (steady_flow || r < 55) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 95) return $urandom_range(10, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_limit();
    case ($urandom_range(4))
      0: return CFG_DATA_W'($urandom_range(4, 1));
      1: return CFG_DATA_W'($urandom_range(40, 5));
      2: return CFG_DATA_W'($urandom_range(255, 100));
      3: return CFG_DATA_W'(NODE_DEPTH);
      default: return CFG_DATA_W'($urandom_range(511, 257));
    endcase
  endfunction

  function automatic item_t make_item(bit [7:0] s, bit [7:0] d);
    return item_t'({s, d});
  endfunction

  // Random edge: in-range pairs, held pairs in either order, self-loops,
  // endpoints past the limit, and raw random bits.
  function automatic item_t random_edge();
    int lim;
    int pick;
    bit [15:0] key;
    bit [7:0] node;
    item_t it;
    lim = sb.active_limit();
    pick = $urandom_range(99);
    key = 16'($urandom_range(65535));
    it = item_t'(key);
    if (lim == 0 || pick >= 85) return it;
    if (pick < 35) begin
      it.src_node = 8'($urandom_range(lim - 1));
      it.dst_node = 8'($urandom_range(lim - 1));
    end else if (pick < 60 && sb.edge_keys.size() > 0) begin
      key = sb.edge_keys[$urandom_range(sb.edge_keys.size() - 1)];
      it = $urandom_range(1) ? make_item(key[7:0], key[15:8]) : item_t'(key);
    end else if (pick < 72) begin
      it.src_node = 8'($urandom_range(lim - 1));
      it.dst_node = it.src_node;
    end else if (lim < NODE_DEPTH) begin
      node = 8'($urandom_range(NODE_DEPTH - 1, lim));
      if ($urandom_range(1)) it.src_node = node;
      else it.dst_node = node;
    end
    return it;
  endfunction

  // Offers one request and returns at the edge that accepts it, leaving
  // start high so that a back-to-back request follows without a gap.
  task automatic send_request(item_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    item <= it;
    do @(posedge clk); while (busy);
    sb.note_request(it);
  endtask

  // Stops requests and waits for every outstanding result.
  task automatic quiesce();
    start <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
  endtask

  // Writes both registers back to back; only called while the unit is idle.
  task automatic set_config(bit dir, logic [CFG_DATA_W-1:0] lim);
    cfg_valid <= 1'b1;
    cfg_index <= REG_DIRECTED;
    cfg_data <= CFG_DATA_W'(dir);
    do @(posedge clk); while (!cfg_ready);
    sb.set_register(REG_DIRECTED, CFG_DATA_W'(dir));
    cfg_index <= REG_NODE_LIMIT;
    cfg_data <= lim;
    do @(posedge clk); while (!cfg_ready);
    sb.set_register(REG_NODE_LIMIT, lim);
    cfg_valid <= 1'b0;
    write_count += 2;
  endtask

  initial begin
    sb = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Undirected: self-loops, both extremes and reversed duplicates.
    set_config(1'b0, NODE_LIMIT_RESET);
    send_request(make_item(8'd0, 8'd0));
    send_request(make_item(8'd0, 8'd0));
    send_request(make_item(8'd255, 8'd255));
    send_request(make_item(8'd0, 8'd255));
    send_request(make_item(8'd255, 8'd0));
    send_request(make_item(8'd170, 8'd85));
    send_request(make_item(8'd85, 8'd170));
    send_request(make_item(8'd1, 8'd2));
    send_request(make_item(8'd2, 8'd1));

    // Directed with edges already held: reversed pairs are now new.
    quiesce();
    set_config(1'b1, 9'd256);
    send_request(make_item(8'd2, 8'd1));
    send_request(make_item(8'd0, 8'd0));
    send_request(make_item(8'd255, 8'd0));
    send_request(make_item(8'd0, 8'd255));
    send_request(make_item(8'd85, 8'd170));

    // Smallest limits, including zero where every edge is refused.
    quiesce();
    set_config(1'b1, 9'd1);
    send_request(make_item(8'd0, 8'd0));
    send_request(make_item(8'd0, 8'd1));
    send_request(make_item(8'd1, 8'd0));
    send_request(make_item(8'd255, 8'd255));
    quiesce();
    set_config(1'b1, 9'd0);
    send_request(make_item(8'd0, 8'd0));

    // Limits above capacity act as the capacity.
    quiesce();
    set_config(1'b1, 9'd511);
    send_request(make_item(8'd255, 8'd254));
    quiesce();
    set_config(1'b1, 9'd257);
    send_request(make_item(8'd254, 8'd255));
    quiesce();
    set_config(1'b0, 9'd256);
    send_request(make_item(8'd254, 8'd255));
    send_request(make_item(8'd3, 8'd200));

    // Random phases, each with its own mode and limit.
    for (int phase = 0; phase < 8; phase++) begin
      quiesce();
      steady_flow = ($urandom_range(3) == 0);
      set_config(1'($urandom_range(1)), pick_limit());
      repeat (70) send_request(random_edge());
    end

    quiesce();
    repeat (8) @(posedge clk);

    $display("Covered %0d requests and %0d register writes; %0d results checked.",
             sb.request_count, write_count, sb.result_count);
    $display("Outcomes: %0d added, %0d duplicate, %0d table full, %0d out of range.",
             sb.status_seen[ST_ADDED], sb.status_seen[ST_DUPLICATE],
             sb.status_seen[ST_FULL], sb.status_seen[ST_RANGE]);
    if (sb.fault_count == 0) begin
      $display("PASS edge_set_insert_with_degree_unit");
    end else begin
      $display("%0d mismatches in total", sb.fault_count);
      $display("FAIL edge_set_insert_with_degree_unit");
    end
    $finish;
  end

endmodule

// ===== edge_set_insert_with_degree_unit.f =====
src/esid_pkg.sv
src/esid_ctrl.sv
src/esid_dp.sv
src/edge_set_insert_with_degree_unit.sv
src/esid_checker.sv
bench/tb_top.sv
